// ----- sv/pkd_pkg.sv -----
// ----------------------------------------------------------------------------
// pkd_pkg
// Shared types and constants for the threshold peak detector with an
// exponential running average.
// ----------------------------------------------------------------------------
`default_nettype none

package pkd_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 16;
    localparam int SEARCH_LEN_MAX       = 1023;
    localparam int BACK_SAT             = 1025;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int RISE_W      = 16;
    localparam int LOOK_W      = 10;
    localparam int ALPHA_W     = 16;
    localparam int BACK_W      = 11;
    localparam int FRAC_W      = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RISE_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING   = 2'd2;

    localparam logic [RISE_W-1:0]  RISE_FACTOR_RESET = 16'd1024;
    localparam logic [LOOK_W-1:0]  SEARCH_LEN_RESET  = 10'd10;
    localparam logic [ALPHA_W-1:0] SMOOTHING_RESET   = 16'd66;

    typedef struct packed {
        logic [RISE_W-1:0]  rise_factor;
        logic [LOOK_W-1:0]  search_len;
        logic [ALPHA_W-1:0] smoothing;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/peak_detector_avg_threshold_top.sv -----
// ----------------------------------------------------------------------------
// peak_detector_avg_threshold_top
// Threshold peak detector with an exponential running average.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the sink accepts results and
// returns one result per sample: the sample is held in the input register
// and then passes through the detector update into the result register. The
// rate of one item per clock is set by the state update loop, a single
// multiply and add on the running average. The result waits in its register
// while the sink stalls, and the input register still takes one more sample
// during that time.
`default_nettype none

module peak_detector_avg_threshold_top #(
    parameter  int SAMPLE_WIDTH = pkd_pkg::SAMPLE_WIDTH_DEFAULT,
    localparam int S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_FIELDS_W   = 2 * SAMPLE_WIDTH + pkd_pkg::BACK_W,
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pkd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: sample.
    input  wire logic [S_TDATA_W-1:0]            s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: peak_value, peak_back, average.
    output logic [M_TDATA_W-1:0]                 m_tdata,
    // Fields from bit 0: peak_flag.
    output logic [0:0]                           m_tuser
);

    pkd_pkg::cfg_t                  cfg;
    logic                           peak_flag;
    logic signed [SAMPLE_WIDTH-1:0] peak_value;
    logic [pkd_pkg::BACK_W-1:0]     peak_back;
    logic signed [SAMPLE_WIDTH-1:0] average;

    pkd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pkd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_sample     (s_tdata[SAMPLE_WIDTH-1:0]),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_peak_flag  (peak_flag),
        .m_peak_value (peak_value),
        .m_peak_back  (peak_back),
        .m_average    (average)
    );

    assign m_tdata = M_TDATA_W'({average, peak_back, peak_value});
    assign m_tuser = peak_flag;

endmodule

`default_nettype wire

// ----- sv/pkd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pkd_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pkd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pkd_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output pkd_pkg::cfg_t                        cfg
);

    pkd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_factor <= pkd_pkg::RISE_FACTOR_RESET;
            cfg_reg.search_len  <= pkd_pkg::SEARCH_LEN_RESET;
            cfg_reg.smoothing   <= pkd_pkg::SMOOTHING_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pkd_pkg::REG_RISE_FACTOR: begin
                    cfg_reg.rise_factor <= cfg_wr_data[pkd_pkg::RISE_W-1:0];
                end
                pkd_pkg::REG_SEARCH_LEN: begin
                    cfg_reg.search_len <= cfg_wr_data[pkd_pkg::LOOK_W-1:0];
                end
                pkd_pkg::REG_SMOOTHING: begin
                    cfg_reg.smoothing <= cfg_wr_data[pkd_pkg::ALPHA_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/pkd_core.sv -----
// ----------------------------------------------------------------------------
// pkd_core
// Input register, detector state with its combinational update, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_core #(
    parameter int SAMPLE_WIDTH = pkd_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pkd_pkg::cfg_t                     cfg,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    s_sample,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_peak_flag,
    output logic signed [SAMPLE_WIDTH-1:0]         m_peak_value,
    output logic [pkd_pkg::BACK_W-1:0]             m_peak_back,
    output logic signed [SAMPLE_WIDTH-1:0]         m_average
);

    localparam int FW     = pkd_pkg::FRAC_W;
    localparam int AVG_W  = SAMPLE_WIDTH + FW;
    localparam int CMP_W  = AVG_W + 18;
    localparam int DIFF_W = AVG_W + 1;
    localparam int PROD_W = DIFF_W + 17;
    localparam int LW     = pkd_pkg::LOOK_W;
    localparam int BW     = pkd_pkg::BACK_W;

    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;

    logic                           searching_reg, searching_next;
    logic signed [AVG_W-1:0]        avg_reg, avg_next;
    logic signed [SAMPLE_WIDTH-1:0] best_value_reg, best_value_next;
    logic                           best_valid_reg, best_valid_next;
    logic [LW-1:0]                  countdown_reg, countdown_next;
    logic [BW-1:0]                  since_best_reg, since_best_next;

    logic                           out_valid_reg;
    logic                           out_flag_reg, flag_next;
    logic signed [SAMPLE_WIDTH-1:0] out_value_reg, value_next;
    logic [BW-1:0]                  out_back_reg, back_next;
    logic signed [SAMPLE_WIDTH-1:0] out_avg_reg;

    logic                           fire;
    logic signed [CMP_W-1:0]        lhs;
    logic signed [CMP_W-1:0]        rhs;
    logic [16:0]                    rise_scale;
    logic signed [DIFF_W-1:0]       diff;
    logic signed [PROD_W-1:0]       prod;
    logic signed [AVG_W-1:0]        avg_upd;
    logic                           arm;
    logic                           new_max;
    logic [BW-1:0]                  since_inc;
    logic [LW-1:0]                  look_clamped;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        lhs        = {{(CMP_W - SAMPLE_WIDTH - 28){in_sample_reg[SAMPLE_WIDTH-1]}},
                      in_sample_reg, 28'd0};
        rise_scale = 17'd4096 + {1'b0, cfg.rise_factor};
        rhs        = avg_reg * $signed({1'b0, rise_scale});
        arm        = !searching_reg && (lhs > rhs);

        diff    = {in_sample_reg[SAMPLE_WIDTH-1], in_sample_reg, {FW{1'b0}}}
                  - {avg_reg[AVG_W-1], avg_reg};
        prod    = diff * $signed({1'b0, cfg.smoothing});
        avg_upd = avg_reg + prod[AVG_W+FW-1:FW];

        new_max   = !best_valid_reg || (in_sample_reg > best_value_reg);
        since_inc = (since_best_reg < BW'(pkd_pkg::BACK_SAT)) ? since_best_reg + 1'b1
                                                              : since_best_reg;
        look_clamped = (32'(cfg.search_len) > pkd_pkg::SEARCH_LEN_MAX)
                       ? LW'(pkd_pkg::SEARCH_LEN_MAX) : cfg.search_len;

        searching_next  = searching_reg;
        avg_next        = avg_reg;
        best_value_next = best_value_reg;
        best_valid_next = best_valid_reg;
        countdown_next  = countdown_reg;
        since_best_next = since_best_reg;
        flag_next       = 1'b0;
        value_next      = '0;
        back_next       = '0;

        if (!searching_reg) begin
            if (arm) begin
                searching_next  = 1'b1;
                countdown_next  = look_clamped;
                best_valid_next = 1'b0;
                since_best_next = '0;
            end else begin
                avg_next = avg_upd;
            end
        end else begin
            if (new_max) begin
                best_value_next = in_sample_reg;
                best_valid_next = 1'b1;
                since_best_next = '0;
            end else begin
                since_best_next = since_inc;
                if (countdown_reg == '0) begin
                    flag_next      = 1'b1;
                    value_next     = best_value_reg;
                    back_next      = since_inc;
                    searching_next = 1'b0;
                    avg_next       = {in_sample_reg, {FW{1'b0}}};
                end
            end
            if (countdown_reg != '0) begin
                countdown_next = countdown_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            searching_reg  <= 1'b0;
            avg_reg        <= '0;
            best_value_reg <= '0;
            best_valid_reg <= 1'b0;
            countdown_reg  <= '0;
            since_best_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg  <= 1'b1;
                searching_reg  <= searching_next;
                avg_reg        <= avg_next;
                best_value_reg <= best_value_next;
                best_valid_reg <= best_valid_next;
                countdown_reg  <= countdown_next;
                since_best_reg <= since_best_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg <= s_sample;
        end
        if (fire) begin
            out_flag_reg  <= flag_next;
            out_value_reg <= value_next;
            out_back_reg  <= back_next;
            out_avg_reg   <= avg_next[AVG_W-1:FW];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_peak_flag  = out_flag_reg;
    assign m_peak_value = out_value_reg;
    assign m_peak_back  = out_back_reg;
    assign m_average    = out_avg_reg;

endmodule

`default_nettype wire

// ----- sv/pkd_checker.sv -----
// ----------------------------------------------------------------------------
// pkd_checker
// Port-level checks for the peak detector, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pkd_checker #(
    parameter int SAMPLE_WIDTH = pkd_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int M_TDATA_W    = 48
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [0:0]           m_tuser
);

    localparam int BW     = pkd_pkg::BACK_W;
    localparam int BACK_L = SAMPLE_WIDTH;

    logic [SAMPLE_WIDTH-1:0] peak_value;
    logic [BW-1:0]           peak_back;

    assign peak_value = m_tdata[SAMPLE_WIDTH-1:0];
    assign peak_back  = m_tdata[BACK_L+BW-1:BACK_L];

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_no_peak_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (peak_value == '0 && peak_back == '0))
        else $error("peak fields not zero without a peak");

    a_peak_back_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (peak_back != '0 && peak_back <= BW'(pkd_pkg::BACK_SAT)))
        else $error("peak distance out of range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind peak_detector_avg_threshold_top pkd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .M_TDATA_W    (M_TDATA_W)
) u_pkd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
